// ----- hw/rtl/gaussian_3x3_blur_top_defines.svh -----
// Assertion macros shared by the blur checker.
// No dependencies; include guarded.
`ifndef GAUSSIAN_3X3_BLUR_TOP_DEFINES_SVH
`define GAUSSIAN_3X3_BLUR_TOP_DEFINES_SVH

// Assert a property on a given clock and active-low reset
`define GB3_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Assert a property on the block clock and reset
`define GB3_ASSERT(lbl, prop, msg) \
  `GB3_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

// ----- hw/rtl/gb3_pkg.sv -----
// Shared widths, register indexes and the pixel tag type of the 3x3 blur.
// No dependencies.
package gb3_pkg;

  localparam int unsigned PIX_W      = 8;
  localparam int unsigned COL_W      = 10;
  localparam int unsigned ROW_W      = 12;
  localparam int unsigned WID_W      = 11;
  localparam int unsigned HGT_W      = 12;
  localparam int unsigned MAX_WIDTH  = 1024;
  localparam int unsigned LB_AW      = $clog2(MAX_WIDTH);
  localparam int unsigned SUM_W      = 12;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 12;
  localparam int unsigned TDATA_IN_W  = 8;
  localparam int unsigned TDATA_OUT_W = 32;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

  // Geometry reset values and limits
  localparam logic [WID_W-1:0] WIDTH_RST  = 11'd32;
  localparam logic [HGT_W-1:0] HEIGHT_RST = 12'd24;
  localparam logic [WID_W-1:0] WIDTH_MIN  = 11'd3;
  localparam logic [WID_W-1:0] WIDTH_MAX  = WID_W'(MAX_WIDTH);
  localparam logic [HGT_W-1:0] HEIGHT_MIN = 12'd3;

  // Position and result flags of one pixel in flight
  typedef struct packed {
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic             emit;
    logic             last;
  } pix_tag_t;

endpackage

// ----- hw/rtl/gb3_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module gb3_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port; data holds until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/gb3_raster.sv -----
// Geometry registers and raster counters of the 3x3 blur.
// Depends on gb3_pkg.
module gb3_raster (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [gb3_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [gb3_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           advance_i,
  output gb3_pkg::pix_tag_t              tag_o
);
  import gb3_pkg::*;

  logic [WID_W-1:0] width_q, width_d;
  logic [HGT_W-1:0] height_q, height_d;
  logic [COL_W-1:0] col_q, col_d;
  logic [ROW_W-1:0] row_q, row_d;
  logic [WID_W-1:0] used_w;
  logic [HGT_W-1:0] used_h;
  logic [WID_W-1:0] col_ext;
  logic [ROW_W:0]   row_next;

  // Clamp geometry to the supported range
  always_comb begin
    used_w = width_q;
    if (width_q < WIDTH_MIN) begin
      used_w = WIDTH_MIN;
    end else if (width_q > WIDTH_MAX) begin
      used_w = WIDTH_MAX;
    end
    used_h = (height_q < HEIGHT_MIN) ? HEIGHT_MIN : height_q;
  end

  assign col_ext  = {1'b0, col_q};
  assign row_next = {1'b0, row_q} + 1'b1;

  // Tag the pixel at the current position
  always_comb begin
    tag_o.col  = col_q;
    tag_o.row  = row_q;
    tag_o.emit = (col_ext < used_w) && (row_q < used_h) &&
                 (col_q >= COL_W'(2)) && (row_q >= ROW_W'(2));
    tag_o.last = (col_ext == used_w - 1'b1) && (row_q == used_h - 1'b1);
  end

  // Register writes
  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_FRAME_WIDTH:  width_d  = cfg_data_i[WID_W-1:0];
        REG_FRAME_HEIGHT: height_d = cfg_data_i[HGT_W-1:0];
        default: ;
      endcase
    end
  end

  // Advance column, wrap row at end of line and frame
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (advance_i) begin
      if (col_ext + 1'b1 >= used_w) begin
        col_d = '0;
        row_d = (row_next >= {1'b0, used_h}) ? '0 : row_next[ROW_W-1:0];
      end else begin
        col_d = col_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RST;
      height_q <= HEIGHT_RST;
      col_q    <= '0;
      row_q    <= '0;
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
      col_q    <= col_d;
      row_q    <= row_d;
    end
  end

endmodule

// ----- hw/rtl/gb3_win.sv -----
// 3x3 window registers and the [1 2 1; 2 4 2; 1 2 1] / 16 kernel.
// Depends on gb3_pkg.
module gb3_win (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    shift_i,
  input  logic [gb3_pkg::PIX_W-1:0] up2_i,
  input  logic [gb3_pkg::PIX_W-1:0] up1_i,
  input  logic [gb3_pkg::PIX_W-1:0] pix_i,
  output logic [gb3_pkg::PIX_W-1:0] blur_o
);
  import gb3_pkg::*;

  // [row*3 + col], row 0 oldest line, col 2 newest column
  logic [PIX_W-1:0] win_q [9];
  logic [PIX_W-1:0] win_d [9];
  logic [SUM_W-1:0] corners, edges, sum;

  // Shift left, load the new column on the right
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      win_d[i*3 + 0] = win_q[i*3 + 1];
      win_d[i*3 + 1] = win_q[i*3 + 2];
    end
    win_d[2] = up2_i;
    win_d[5] = up1_i;
    win_d[8] = pix_i;
  end

  // Weighted sum over the shifted window
  always_comb begin
    corners = SUM_W'(win_d[0]) + SUM_W'(win_d[2]) + SUM_W'(win_d[6]) + SUM_W'(win_d[8]);
    edges   = SUM_W'(win_d[1]) + SUM_W'(win_d[3]) + SUM_W'(win_d[5]) + SUM_W'(win_d[7]);
    sum     = corners + (edges << 1) + (SUM_W'(win_d[4]) << 2);
  end

  assign blur_o = sum[SUM_W-1:4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 9; i++) begin
        win_q[i] <= '0;
      end
    end else if (shift_i) begin
      win_q <= win_d;
    end
  end

endmodule

// ----- hw/rtl/gaussian_3x3_blur_top.sv -----
// Top level of the 3x3 Gaussian blur: stream ports, line buffers, pipeline control.
// Depends on gb3_pkg, gb3_raster, gb3_ram and gb3_win.
//
//  channel | direction | beat contents
//  s_axis  | in        | tdata[7:0] pixel_in
//  m_axis  | out       | tdata[7:0] pixel_out, [17:8] out_col, [29:18] out_row; tlast frame_last
//  cfg     | in        | index 0 frame_width, 1 frame_height; data in cfg_data_i
//
// One pixel per clock unless a result is held by a stalled output. A pixel enters the
// line buffer read stage on acceptance and is filtered into the output register as it
// leaves that stage. The output register stalls only pixels that produce a result; border
// pixels still pass. Reset clears counters, window and valid flags; line buffers are not
// cleared and need no clearing pass.
module gaussian_3x3_blur_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [gb3_pkg::TDATA_IN_W-1:0] s_axis_tdata,   // [7:0] pixel_in
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [gb3_pkg::TDATA_OUT_W-1:0] m_axis_tdata,  // pixel_out, out_col, out_row
  output logic                           m_axis_tlast,   // frame_last
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [gb3_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [gb3_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import gb3_pkg::*;

  logic             accept, s1_adv;
  logic             s1_valid_q, s1_valid_d;
  pix_tag_t         s1_tag_q, cur_tag;
  logic [PIX_W-1:0] s1_pix_q;
  logic [PIX_W-1:0] up1, up2, blur;
  logic             out_valid_q, out_valid_d;
  logic [PIX_W-1:0] out_pix_q;
  logic [COL_W-1:0] out_col_q;
  logic [ROW_W-1:0] out_row_q;
  logic             out_last_q;

  // Handshakes
  assign cfg_ready_o   = 1'b1;
  assign s1_adv        = s1_valid_q && (!s1_tag_q.emit || !out_valid_q || m_axis_tready);
  assign s_axis_tready = !s1_valid_q || s1_adv;
  assign accept        = s_axis_tvalid && s_axis_tready;

  gb3_raster u_raster (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .advance_i   (accept),
    .tag_o       (cur_tag)
  );

  // Line buffer A holds row r-1, B holds row r-2
  gb3_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_line_a (
    .clk_i   (clk_i),
    .we_i    (s1_adv),
    .waddr_i (s1_tag_q.col[LB_AW-1:0]),
    .wdata_i (s1_pix_q),
    .re_i    (accept),
    .raddr_i (cur_tag.col[LB_AW-1:0]),
    .rdata_o (up1)
  );

  gb3_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_line_b (
    .clk_i   (clk_i),
    .we_i    (s1_adv),
    .waddr_i (s1_tag_q.col[LB_AW-1:0]),
    .wdata_i (up1),
    .re_i    (accept),
    .raddr_i (cur_tag.col[LB_AW-1:0]),
    .rdata_o (up2)
  );

  gb3_win u_win (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .shift_i (s1_adv),
    .up2_i   (up2),
    .up1_i   (up1),
    .pix_i   (s1_pix_q),
    .blur_o  (blur)
  );

  // Read stage valid and payload
  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_tag_q <= cur_tag;
      s1_pix_q <= s_axis_tdata[PIX_W-1:0];
    end
  end

  // Output register: load on a result, drop when taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (s1_adv && s1_tag_q.emit) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_tag_q.emit) begin
      out_pix_q  <= blur;
      out_col_q  <= s1_tag_q.col - 1'b1;
      out_row_q  <= s1_tag_q.row - 1'b1;
      out_last_q <= s1_tag_q.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, out_row_q, out_col_q, out_pix_q};
  assign m_axis_tlast  = out_last_q;

endmodule

// ----- hw/rtl/gb3_checker.sv -----
// Port-level checker for the 3x3 blur, bound to the top level.
// Depends on gb3_pkg and gaussian_3x3_blur_top_defines.svh.
`include "gaussian_3x3_blur_top_defines.svh"

module gb3_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic [gb3_pkg::TDATA_IN_W-1:0]  s_axis_tdata,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [gb3_pkg::TDATA_OUT_W-1:0] m_axis_tdata,
  input logic                            m_axis_tlast,
  input logic                            cfg_valid_i,
  input logic                            cfg_ready_o,
  input logic [gb3_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input logic [gb3_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import gb3_pkg::*;

  // A stalled result beat holds
  `GB3_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "result beat changed while stalled")

  // Border pixels never leave the block
  `GB3_ASSERT(a_interior, m_axis_tvalid |-> m_axis_tdata[17:8] != 10'd0 && m_axis_tdata[29:18] != 12'd0, "border pixel emitted")

  // Input stalls only behind a full, blocked output
  `GB3_ASSERT(a_no_idle_stall, !s_axis_tready |-> m_axis_tvalid && !m_axis_tready, "input stalled without output backpressure")

endmodule

bind gaussian_3x3_blur_top gb3_checker u_gb3_checker (.*);
